@@ design/gwf_pkg.sv @@
// Shared types, codes and helper functions of the grid wall follower walker.
`default_nettype none

package gwf_pkg;

    // Position of the walker: signed, with room for one cell outside the grid
    localparam int POS_W   = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    typedef logic signed [POS_W-1:0] t_pos;

    // Command codes
    localparam logic [1:0] CMD_WRITE   = 2'd0;
    localparam logic [1:0] CMD_RESTART = 2'd1;
    localparam logic [1:0] CMD_STEP    = 2'd2;

    // Walk status codes
    localparam logic [1:0] ST_WALKING = 2'd0;
    localparam logic [1:0] ST_ARRIVED = 2'd1;
    localparam logic [1:0] ST_ON_WALL = 2'd2;
    localparam logic [1:0] ST_LIMIT   = 2'd3;

    // Headings
    localparam logic [1:0] DIR_EAST  = 2'd0;
    localparam logic [1:0] DIR_SOUTH = 2'd1;
    localparam logic [1:0] DIR_WEST  = 2'd2;
    localparam logic [1:0] DIR_NORTH = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIDE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_ROW  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_COL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GOAL_ROW   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GOAL_COL   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_LIMIT = 3'd5;

    // Configuration reset values
    localparam logic [6:0]  GRID_SIDE_RST  = 7'd64;
    localparam logic [15:0] STEP_LIMIT_RST = 16'd10000;

    typedef struct packed {
        logic [1:0] command;
        logic [5:0] cell_row;
        logic [5:0] cell_col;
        logic       cell_wall;
    } t_cmd;

    typedef struct packed {
        logic [1:0]  heading;
        logic        moved;
        logic [1:0]  walk_status;
        logic [15:0] steps_taken;
    } t_result;

    typedef struct packed {
        logic [6:0]  grid_side;
        logic [5:0]  start_row;
        logic [5:0]  start_col;
        logic [5:0]  goal_row;
        logic [5:0]  goal_col;
        logic [15:0] step_limit;
    } t_cfg;

    // Row of the neighbor in direction dir
    function automatic t_pos step_row(input t_pos row, input logic [1:0] dir);
        t_pos res;
        case (dir)
            DIR_SOUTH: res = t_pos'(row + t_pos'(1));
            DIR_NORTH: res = t_pos'(row - t_pos'(1));
            default:   res = row;
        endcase
        return res;
    endfunction

    // Column of the neighbor in direction dir
    function automatic t_pos step_col(input t_pos col, input logic [1:0] dir);
        t_pos res;
        case (dir)
            DIR_EAST: res = t_pos'(col + t_pos'(1));
            DIR_WEST: res = t_pos'(col - t_pos'(1));
            default:  res = col;
        endcase
        return res;
    endfunction

    // True if the cell lies inside the side in use
    function automatic logic in_grid(input t_pos row, input t_pos col, input logic [8:0] side);
        return !row[POS_W-1] && !col[POS_W-1] &&
               ({1'b0, row} < side) && ({1'b0, col} < side);
    endfunction

endpackage

`default_nettype wire

@@ design/gwf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module gwf_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write on enable, read every cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ design/gwf_cfg.sv @@
// Configuration register file of the grid wall follower walker.
`default_nettype none

module gwf_cfg (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [gwf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [gwf_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output gwf_pkg::t_cfg                        o_cfg
);

    gwf_pkg::t_cfg r_cfg;
    gwf_pkg::t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Decode the index and take the low bits of the word
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                gwf_pkg::CFG_GRID_SIDE:  n_cfg.grid_side  = i_cfg_data[6:0];
                gwf_pkg::CFG_START_ROW:  n_cfg.start_row  = i_cfg_data[5:0];
                gwf_pkg::CFG_START_COL:  n_cfg.start_col  = i_cfg_data[5:0];
                gwf_pkg::CFG_GOAL_ROW:   n_cfg.goal_row   = i_cfg_data[5:0];
                gwf_pkg::CFG_GOAL_COL:   n_cfg.goal_col   = i_cfg_data[5:0];
                gwf_pkg::CFG_STEP_LIMIT: n_cfg.step_limit = i_cfg_data[15:0];
                default:                 n_cfg = r_cfg;
            endcase
        end
    end

    // Hold the registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.grid_side  <= gwf_pkg::GRID_SIDE_RST;
            r_cfg.start_row  <= 6'd0;
            r_cfg.start_col  <= 6'd0;
            r_cfg.goal_row   <= 6'd0;
            r_cfg.goal_col   <= 6'd0;
            r_cfg.step_limit <= gwf_pkg::STEP_LIMIT_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

`default_nettype wire

@@ design/gwf_walker.sv @@
// Walker sequencer: wall memory, walker state and the step probe loop.
`default_nettype none

module gwf_walker #(
    parameter int MAX_SIDE = 64
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire gwf_pkg::t_cmd    i_cmd,
    input  wire gwf_pkg::t_cfg    i_cfg,
    output logic                  o_busy,
    output logic                  o_done,
    output gwf_pkg::t_result      o_result
);

    localparam int DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [AW-1:0] SIDE_K = AW'(MAX_SIDE);
    localparam logic [8:0]    SIDE_MAX = 9'(MAX_SIDE);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CUR   = 4'b0010,
        S_LEFT  = 4'b0100,
        S_AHEAD = 4'b1000
    } t_state;

    t_state        r_state,   n_state;
    gwf_pkg::t_pos r_row,     n_row;
    gwf_pkg::t_pos r_col,     n_col;
    logic [1:0]    r_heading, n_heading;
    logic [15:0]   r_count,   n_count;
    logic [1:0]    r_finish,  n_finish;
    logic          r_moved,   n_moved;
    logic          r_done,    n_done;
    logic [1:0]    r_probe,   n_probe;
    logic [1:0]    r_turns,   n_turns;
    logic          r_in_grid;

    logic          accept;
    logic [8:0]    side;
    gwf_pkg::t_pos pr_row, pr_col;
    logic [1:0]    pr_dir;
    logic [7:0]    pr_row_u, pr_col_u;
    logic [AW-1:0] rd_addr, wr_addr;
    logic          wr_en;
    logic          rd_data;
    logic          blocked;
    logic          at_goal;
    logic [1:0]    mv_dir;
    gwf_pkg::t_pos mv_row, mv_col;
    logic [15:0]   mv_count;
    logic [1:0]    mv_finish;
    gwf_pkg::t_pos goal_row, goal_col;

    assign accept = i_start && !o_busy;
    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;

    assign o_result.heading     = r_heading;
    assign o_result.moved       = r_moved;
    assign o_result.walk_status = r_finish;
    assign o_result.steps_taken = r_count;

    // Side in use is the smaller of the register and the memory side
    assign side = ({2'b00, i_cfg.grid_side} < SIDE_MAX) ? {2'b00, i_cfg.grid_side} : SIDE_MAX;

    assign goal_row = gwf_pkg::t_pos'({2'b00, i_cfg.goal_row});
    assign goal_col = gwf_pkg::t_pos'({2'b00, i_cfg.goal_col});
    assign at_goal  = (r_row == goal_row) && (r_col == goal_col);

    // Pick the cell to read this cycle; data comes back next cycle
    always_comb begin
        case (r_state)
            S_CUR:   pr_dir = r_heading - 2'd1;
            S_LEFT:  pr_dir = r_heading;
            S_AHEAD: pr_dir = r_probe + 2'd1;
            default: pr_dir = r_heading;
        endcase
        if (r_state == S_IDLE) begin
            pr_row = r_row;
            pr_col = r_col;
        end else begin
            pr_row = gwf_pkg::step_row(r_row, pr_dir);
            pr_col = gwf_pkg::step_col(r_col, pr_dir);
        end
    end

    assign pr_row_u = pr_row;
    assign pr_col_u = pr_col;
    assign rd_addr  = AW'(AW'(pr_row_u) * SIDE_K + AW'(pr_col_u));

    // Cell writes go straight to memory on accept
    assign wr_en   = accept && (i_cmd.command == gwf_pkg::CMD_WRITE) &&
                     ({3'b000, i_cmd.cell_row} < SIDE_MAX) &&
                     ({3'b000, i_cmd.cell_col} < SIDE_MAX);
    assign wr_addr = AW'(AW'(i_cmd.cell_row) * SIDE_K + AW'(i_cmd.cell_col));

    gwf_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_walls (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (i_cmd.cell_wall),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // Cells outside the grid count as walls
    assign blocked = !r_in_grid || rd_data;

    // Move target: left turn, first open heading, or full circle
    always_comb begin
        if (r_state == S_LEFT) begin
            mv_dir = r_heading - 2'd1;
        end else if (blocked) begin
            mv_dir = r_probe + 2'd1;
        end else begin
            mv_dir = r_probe;
        end
        mv_row   = gwf_pkg::step_row(r_row, mv_dir);
        mv_col   = gwf_pkg::step_col(r_col, mv_dir);
        mv_count = r_count + 16'd1;
        if ((mv_row == goal_row) && (mv_col == goal_col)) begin
            mv_finish = gwf_pkg::ST_ARRIVED;
        end else if (mv_count >= i_cfg.step_limit) begin
            mv_finish = gwf_pkg::ST_LIMIT;
        end else begin
            mv_finish = gwf_pkg::ST_WALKING;
        end
    end

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_row     = r_row;
        n_col     = r_col;
        n_heading = r_heading;
        n_count   = r_count;
        n_finish  = r_finish;
        n_moved   = r_moved;
        n_done    = 1'b0;
        n_probe   = r_probe;
        n_turns   = r_turns;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_moved = 1'b0;
                    case (i_cmd.command)
                        gwf_pkg::CMD_RESTART: begin
                            n_row     = gwf_pkg::t_pos'({2'b00, i_cfg.start_row});
                            n_col     = gwf_pkg::t_pos'({2'b00, i_cfg.start_col});
                            n_heading = gwf_pkg::DIR_SOUTH;
                            n_count   = 16'd0;
                            n_finish  = gwf_pkg::ST_WALKING;
                            n_done    = 1'b1;
                        end
                        gwf_pkg::CMD_STEP: begin
                            if (r_finish == gwf_pkg::ST_WALKING) begin
                                n_state = S_CUR;
                            end else begin
                                n_done = 1'b1;
                            end
                        end
                        default: n_done = 1'b1;
                    endcase
                end
            end
            S_CUR: begin
                if (at_goal) begin
                    n_finish = gwf_pkg::ST_ARRIVED;
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                end else if (r_count >= i_cfg.step_limit) begin
                    n_finish = gwf_pkg::ST_LIMIT;
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                end else if (blocked) begin
                    n_finish = gwf_pkg::ST_ON_WALL;
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_state = S_LEFT;
                end
            end
            S_LEFT, S_AHEAD: begin
                if ((r_state == S_LEFT && !blocked) ||
                    (r_state == S_AHEAD && (!blocked || r_turns == 2'd3))) begin
                    n_heading = mv_dir;
                    n_row     = mv_row;
                    n_col     = mv_col;
                    n_count   = mv_count;
                    n_finish  = mv_finish;
                    n_moved   = 1'b1;
                    n_done    = 1'b1;
                    n_state   = S_IDLE;
                end else if (r_state == S_LEFT) begin
                    n_probe = r_heading;
                    n_turns = 2'd0;
                    n_state = S_AHEAD;
                end else begin
                    n_probe = r_probe + 2'd1;
                    n_turns = r_turns + 2'd1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Advance the control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_row     <= '0;
            r_col     <= '0;
            r_heading <= gwf_pkg::DIR_SOUTH;
            r_count   <= 16'd0;
            r_finish  <= gwf_pkg::ST_WALKING;
            r_moved   <= 1'b0;
            r_done    <= 1'b0;
            r_probe   <= 2'd0;
            r_turns   <= 2'd0;
        end else begin
            r_state   <= n_state;
            r_row     <= n_row;
            r_col     <= n_col;
            r_heading <= n_heading;
            r_count   <= n_count;
            r_finish  <= n_finish;
            r_moved   <= n_moved;
            r_done    <= n_done;
            r_probe   <= n_probe;
            r_turns   <= n_turns;
        end
    end

    // Track whether the cell read this cycle lies inside the grid
    always_ff @(posedge i_clk) begin
        r_in_grid <= gwf_pkg::in_grid(pr_row, pr_col, side);
    end

    // A move always bumps the count by one
    a_move_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done && r_moved |-> r_count == 16'($past(r_count) + 16'd1))
        else $error("move without count increment");

    // Only a walking walker moves
    a_move_walking: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done && r_moved |-> $past(r_finish) == gwf_pkg::ST_WALKING)
        else $error("move from a finished walk");

    // The result strobe comes with the sequencer back at rest
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_state == S_IDLE)
        else $error("result strobe while busy");

    // A walking step always starts the probe sequence
    a_step_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_cmd.command == gwf_pkg::CMD_STEP && r_finish == gwf_pkg::ST_WALKING
        |=> o_busy && !r_done)
        else $error("walking step did not start");

endmodule

`default_nettype wire

@@ design/grid_wall_follower_walker.sv @@
// Top level of the grid wall follower walker: configuration and walker.
//
//  Channel   Ports                                        Direction  Handshake
//  command   start, busy, i_cmd                           in         start && !busy
//  result    o_done, o_result                             out        o_done, one cycle
//  config    i_cfg_valid, o_cfg_ready, i_cfg_index/data   in         valid && ready
//
// Write, restart, an unused command and a step on a finished walk strobe a
// result in the cycle after acceptance. A walking step reads the wall memory
// once per cycle (current cell, left cell, then up to four cells ahead) and
// strobes its result when its probes end. start may be raised again in the
// strobe cycle. Reset is synchronous and active low; the wall memory is not
// cleared and must be written before it is read. The result cannot be stalled.
`default_nettype none

module grid_wall_follower_walker #(
    parameter int MAX_SIDE = 64
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire gwf_pkg::t_cmd                   i_cmd,
    output logic                                 o_done,
    output gwf_pkg::t_result                     o_result,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [gwf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [gwf_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    gwf_pkg::t_cfg cfg;

    gwf_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    gwf_walker #(
        .MAX_SIDE (MAX_SIDE)
    ) u_walker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_cmd    (i_cmd),
        .i_cfg    (cfg),
        .o_busy   (busy),
        .o_done   (o_done),
        .o_result (o_result)
    );

endmodule

`default_nettype wire
